>>> src/y2y_pkg.sv
// y2y_pkg: shared constants and types for the YUY2 to YV12 converter.
// No dependencies; imported by the converter top level, its checkers and the testbench.

package y2y_pkg;

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    // Size compares cover limits up to 8192
    localparam int SIZE_CMP_W = 14;

    // Frame addressing
    localparam int ADDR_W       = 23;
    localparam int LUMA_ADDR_W  = 22;
    localparam int CHROMA_IDX_W = 20;
    localparam int AREA_W       = 2 * CFG_DATA_W;

    localparam int CHROMA_W = 8;
    localparam int LINE_W   = 2 * CHROMA_W;

    localparam logic [1:0] BYTES_LUMA   = 2'd2;
    localparam logic [1:0] BYTES_CHROMA = 2'd1;

    // One byte-write transaction, write_address in the lowest bits
    typedef struct packed {
        logic [1:0]        byte_count;
        logic [7:0]        second_byte;
        logic [7:0]        first_byte;
        logic [ADDR_W-1:0] write_address;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

>>> src/y2y_ram.sv
// y2y_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; used for the chroma line store of the converter.

module y2y_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/yuy2_to_yv12_converter.sv
// yuy2_to_yv12_converter: YUY2 macropixel stream to YV12 planar byte writes.
// Depends on y2y_pkg and y2y_ram (chroma line store).
//
// Usage:
//   Slave stream (s_*): one YUY2 macropixel per transaction, raster order.
//   Master stream (m_*): byte-write transactions into a planar YV12 frame.
//   Luma pairs go to the Y plane from address 0, averaged chroma of each
//   row pair goes to the V plane at W*H and the U plane at W*H*5/4.
//   m_tlast marks the last write caused by one macropixel, m_tuser the last
//   write of the frame.
//   cfg_we/cfg_index/cfg_wdata write frame width (index 0) or height
//   (index 1); any write restarts the frame. Write only while idle.
// Timing:
//   A macropixel passes through the input register before its first write
//   reaches the output register, which drives m_tvalid. Even-row macropixels
//   give one write (luma), odd-row macropixels three writes (luma, U, V),
//   issued by the single output register at one write per cycle while
//   m_tready is high or the output register is empty.
//   Reset (aresetn low, synchronous) empties both registers, restores
//   640x480 and restarts the frame. The line store is not cleared.
//   While m_tready is low the output register holds, the input register
//   fills, and s_tready drops.

module yuy2_to_yv12_converter #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Slave stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: luma_first[7:0], chroma_blue[15:8], luma_second[23:16], chroma_red[31:24]
    input  logic [y2y_pkg::S_TDATA_W-1:0]    s_tdata,
    // Master stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: write_address[22:0], first_byte[30:23], second_byte[38:31],
    //          byte_count[40:39], zero[47:41]
    output logic [y2y_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    // m_tuser: frame_done[0]
    output logic                             m_tuser,
    // Configuration
    input  logic                             cfg_we,
    input  logic [y2y_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [y2y_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import y2y_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int COL_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam logic [SIZE_CMP_W-1:0] WIDTH_LIMIT  = SIZE_CMP_W'(MAX_WIDTH);
    localparam logic [SIZE_CMP_W-1:0] HEIGHT_LIMIT = SIZE_CMP_W'(MAX_HEIGHT);

    // Clamp to the limit, force even, at least 2
    function automatic logic [CFG_DATA_W-1:0] eff_size(
        input logic [CFG_DATA_W-1:0] raw,
        input logic [SIZE_CMP_W-1:0] limit
    );
        logic [SIZE_CMP_W-1:0] s;
        s = SIZE_CMP_W'(raw);
        if (s > limit) begin
            s = limit;
        end
        s[0] = 1'b0;
        if (s < SIZE_CMP_W'(2)) begin
            s = SIZE_CMP_W'(2);
        end
        return s[CFG_DATA_W-1:0];
    endfunction

    localparam logic [CFG_DATA_W-1:0] W_RESET = eff_size(FRAME_WIDTH_RESET, WIDTH_LIMIT);
    localparam logic [CFG_DATA_W-1:0] H_RESET = eff_size(FRAME_HEIGHT_RESET, HEIGHT_LIMIT);
    localparam logic [AREA_W-1:0]     AREA_RESET = AREA_W'(W_RESET) * AREA_W'(H_RESET);
    localparam logic [ADDR_W-1:0]     V_BASE_RESET = AREA_RESET[ADDR_W-1:0];
    localparam logic [ADDR_W-1:0]     U_BASE_RESET = ADDR_W'(AREA_RESET + (AREA_RESET >> 2));

    typedef enum logic [1:0] {
        PH_LUMA,
        PH_BLUE,
        PH_RED
    } phase_t;

    // Frame geometry
    logic [CFG_DATA_W-1:0] w_eff_reg, w_eff_next;
    logic [CFG_DATA_W-1:0] h_eff_reg, h_eff_next;
    logic [ADDR_W-1:0]     v_base_reg, v_base_next;
    logic [ADDR_W-1:0]     u_base_reg, u_base_next;
    logic [AREA_W-1:0]     area_next;

    // Raster position
    logic [COL_W-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [LUMA_ADDR_W-1:0]  luma_addr_reg, luma_addr_next;
    logic [CHROMA_IDX_W-1:0] chroma_idx_reg, chroma_idx_next;
    logic                    row_odd;
    logic                    row_end;
    logic                    frame_end;

    // Input register
    logic                    a_valid_reg, a_valid_next;
    logic [7:0]              a_y0_reg, a_y1_reg, a_cb_reg, a_cr_reg;
    logic                    a_odd_reg;
    logic                    a_frame_end_reg;
    logic [LUMA_ADDR_W-1:0]  a_luma_addr_reg;
    logic [CHROMA_IDX_W-1:0] a_chroma_idx_reg;
    phase_t                  ph_reg, ph_next;

    // Output register
    logic                    m_valid_reg, m_valid_next;
    result_t                 m_res_reg, res_next;
    logic                    m_last_reg, last_next;
    logic                    m_done_reg, done_next;

    logic                    in_acc;
    logic                    out_free;
    logic                    load;
    logic                    phase_last;
    logic                    item_done;

    logic [LINE_W-1:0]       line_rd_data;
    logic [CHROMA_W:0]       u_sum, v_sum;

    // ---------------------------------------------------------------
    // Configuration: keep effective sizes and plane bases
    // ---------------------------------------------------------------
    always_comb begin
        w_eff_next = w_eff_reg;
        h_eff_next = h_eff_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  w_eff_next = eff_size(cfg_wdata, WIDTH_LIMIT);
                REG_FRAME_HEIGHT: h_eff_next = eff_size(cfg_wdata, HEIGHT_LIMIT);
                default: ;
            endcase
        end
        area_next   = AREA_W'(w_eff_next) * AREA_W'(h_eff_next);
        v_base_next = area_next[ADDR_W-1:0];
        u_base_next = ADDR_W'(area_next + (area_next >> 2));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_eff_reg  <= W_RESET;
            h_eff_reg  <= H_RESET;
            v_base_reg <= V_BASE_RESET;
            u_base_reg <= U_BASE_RESET;
        end else if (cfg_we) begin
            w_eff_reg  <= w_eff_next;
            h_eff_reg  <= h_eff_next;
            v_base_reg <= v_base_next;
            u_base_reg <= u_base_next;
        end
    end

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    assign out_free   = !m_valid_reg || m_tready;
    assign load       = a_valid_reg && out_free;
    assign phase_last = !a_odd_reg || (ph_reg == PH_RED);
    assign item_done  = load && phase_last;
    assign s_tready   = !a_valid_reg || item_done;
    assign in_acc     = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Raster position, advanced on each accepted transaction
    // ---------------------------------------------------------------
    assign row_odd   = row_reg[0];
    assign row_end   = (SIZE_CMP_W'(col_reg) + SIZE_CMP_W'(1))
                       >= SIZE_CMP_W'(w_eff_reg[CFG_DATA_W-1:1]);
    assign frame_end = row_odd && row_end
                       && ((SIZE_CMP_W'(row_reg) + SIZE_CMP_W'(1)) >= SIZE_CMP_W'(h_eff_reg));

    always_comb begin
        col_next        = col_reg;
        row_next        = row_reg;
        luma_addr_next  = luma_addr_reg;
        chroma_idx_next = chroma_idx_reg;
        if (cfg_we) begin
            col_next        = '0;
            row_next        = '0;
            luma_addr_next  = '0;
            chroma_idx_next = '0;
        end else if (in_acc) begin
            luma_addr_next  = luma_addr_reg + LUMA_ADDR_W'(2);
            chroma_idx_next = chroma_idx_reg + CHROMA_IDX_W'(row_odd);
            priority if (frame_end) begin
                col_next        = '0;
                row_next        = '0;
                luma_addr_next  = '0;
                chroma_idx_next = '0;
            end else if (row_end) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            luma_addr_reg  <= '0;
            chroma_idx_reg <= '0;
        end else begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            luma_addr_reg  <= luma_addr_next;
            chroma_idx_reg <= chroma_idx_next;
        end
    end

    // ---------------------------------------------------------------
    // Chroma line store: write on even rows, read on odd rows
    // ---------------------------------------------------------------
    y2y_ram #(
        .DATA_W (LINE_W),
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (COL_W)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (in_acc && !row_odd),
        .wr_addr (col_reg),
        .wr_data ({s_tdata[31:24], s_tdata[15:8]}),
        .rd_en   (in_acc && row_odd),
        .rd_addr (col_reg),
        .rd_data (line_rd_data)
    );

    // ---------------------------------------------------------------
    // Result selection for the current phase
    // ---------------------------------------------------------------
    assign u_sum = (CHROMA_W + 1)'(line_rd_data[CHROMA_W-1:0]) + (CHROMA_W + 1)'(a_cb_reg);
    assign v_sum = (CHROMA_W + 1)'(line_rd_data[LINE_W-1:CHROMA_W]) + (CHROMA_W + 1)'(a_cr_reg);

    always_comb begin
        res_next  = '0;
        last_next = 1'b0;
        done_next = 1'b0;
        ph_next   = ph_reg;
        unique case (ph_reg)
            PH_BLUE: begin
                res_next.write_address = u_base_reg + ADDR_W'(a_chroma_idx_reg);
                res_next.first_byte    = u_sum[CHROMA_W:1];
                res_next.byte_count    = BYTES_CHROMA;
                ph_next                = PH_RED;
            end
            PH_RED: begin
                res_next.write_address = v_base_reg + ADDR_W'(a_chroma_idx_reg);
                res_next.first_byte    = v_sum[CHROMA_W:1];
                res_next.byte_count    = BYTES_CHROMA;
                last_next              = 1'b1;
                done_next              = a_frame_end_reg;
                ph_next                = PH_LUMA;
            end
            default: begin
                res_next.write_address = ADDR_W'(a_luma_addr_reg);
                res_next.first_byte    = a_y0_reg;
                res_next.second_byte   = a_y1_reg;
                res_next.byte_count    = BYTES_LUMA;
                last_next              = !a_odd_reg;
                ph_next                = a_odd_reg ? PH_BLUE : PH_LUMA;
            end
        endcase
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        if (in_acc) begin
            a_valid_next = 1'b1;
        end else if (item_done) begin
            a_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Input register, phase and output register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            ph_reg      <= PH_LUMA;
        end else begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
            if (in_acc) begin
                ph_reg <= PH_LUMA;
            end else if (load) begin
                ph_reg <= ph_next;
            end
        end

        if (in_acc) begin
            a_y0_reg         <= s_tdata[7:0];
            a_cb_reg         <= s_tdata[15:8];
            a_y1_reg         <= s_tdata[23:16];
            a_cr_reg         <= s_tdata[31:24];
            a_odd_reg        <= row_odd;
            a_frame_end_reg  <= frame_end;
            a_luma_addr_reg  <= luma_addr_reg;
            a_chroma_idx_reg <= chroma_idx_reg;
        end

        if (load) begin
            m_res_reg  <= res_next;
            m_last_reg <= last_next;
            m_done_reg <= done_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, m_res_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_done_reg;

endmodule

>>> src/y2y_checker.sv
// y2y_checker: port-level assertions for yuy2_to_yv12_converter.
// Depends on y2y_pkg; bound to the converter top level at the end of this file.

module y2y_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [y2y_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                             m_tlast,
    input logic                             m_tuser
);

    import y2y_pkg::*;

    result_t res;

    assign res = m_tdata[RESULT_W-1:0];

    // Every write is a luma pair or a single chroma byte
    a_byte_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res.byte_count == BYTES_LUMA || res.byte_count == BYTES_CHROMA))
        else $error("byte_count is neither a luma pair nor a chroma byte");

    // Single chroma bytes carry a zero second byte
    a_chroma_second: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.byte_count == BYTES_CHROMA) |-> (res.second_byte == 8'd0))
        else $error("chroma write with nonzero second byte");

    // The end of a frame is always the V write closing an odd-row macropixel
    a_frame_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && res.byte_count == BYTES_CHROMA))
        else $error("frame_done on a write that is not the final chroma write");

    // Luma pairs land on even addresses
    a_luma_even: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.byte_count == BYTES_LUMA) |-> !res.write_address[0])
        else $error("luma pair at an odd address");

    // Stalled transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output transaction changed or dropped");

endmodule

bind yuy2_to_yv12_converter y2y_checker u_y2y_checker (.*);

>>> verif/y2y_write_checker.sv
`timescale 1ns / 100ps
// y2y_write_checker: predicts the planar frame writes of the YUY2 to YV12 converter
// from the macropixel and register traffic it observes, and compares each write.
// Depends on y2y_pkg for port widths, register indexes and the write layout.

module y2y_write_checker #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [y2y_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [y2y_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             m_tlast,
    input  logic                             m_tuser,
    input  logic                             cfg_we,
    input  logic [y2y_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [y2y_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int                               mismatches,
    output int                               outstanding
);

    import y2y_pkg::*;

    typedef struct packed {
        result_t beat;
        logic    last;
        logic    done;
    } frame_write_t;

    frame_write_t expected_writes[$];

    logic [CFG_DATA_W-1:0]   width_reg;
    logic [CFG_DATA_W-1:0]   height_reg;
    logic [LINE_W-1:0]       chroma_line [0:MAX_WIDTH/2-1];
    logic [9:0]              col_q;
    logic [10:0]             row_q;
    logic [LUMA_ADDR_W-1:0]  luma_q;
    logic [CHROMA_IDX_W-1:0] chroma_idx_q;

    function automatic int unsigned frame_size(input logic [CFG_DATA_W-1:0] r,
                                               input int unsigned limit);
        int unsigned s;
        s = 32'(r);
        if (s > limit)
            s = limit;
        s = s & 32'hFFFF_FFFE;
        if (s < 2)
            s = 2;
        return s;
    endfunction

    task automatic restart_frame();
        col_q        = '0;
        row_q        = '0;
        luma_q       = '0;
        chroma_idx_q = '0;
    endtask

    task automatic queue_write(input logic [31:0] addr, input logic [7:0] b0,
                               input logic [7:0] b1, input logic [1:0] count,
                               input logic last, input logic done);
        frame_write_t wr;
        wr.beat.write_address = addr[ADDR_W-1:0];
        wr.beat.first_byte    = b0;
        wr.beat.second_byte   = b1;
        wr.beat.byte_count    = count;
        wr.last               = last;
        wr.done               = done;
        expected_writes.push_back(wr);
    endtask

    task automatic predict_writes(input logic [S_TDATA_W-1:0] px);
        int unsigned w, h, cols, area;
        logic [7:0]  y0, cb, y1, cr;
        logic [8:0]  u_sum, v_sum;
        logic [15:0] stored;
        logic        odd_row, row_end, frame_end;
        y0        = px[7:0];
        cb        = px[15:8];
        y1        = px[23:16];
        cr        = px[31:24];
        w         = frame_size(width_reg, MAX_WIDTH);
        h         = frame_size(height_reg, MAX_HEIGHT);
        cols      = w / 2;
        odd_row   = row_q[0];
        row_end   = (col_q + 1 >= cols);
        frame_end = odd_row && row_end && (row_q + 1 >= h);
        if (!odd_row) begin
            // even row: park this column's chroma for the row below
            chroma_line[col_q] = {cr, cb};
            queue_write({10'd0, luma_q}, y0, y1, BYTES_LUMA, 1'b1, 1'b0);
        end else begin
            stored = chroma_line[col_q];
            u_sum  = 9'(stored[7:0]) + 9'(cb);
            v_sum  = 9'(stored[15:8]) + 9'(cr);
            area   = w * h;
            queue_write({10'd0, luma_q}, y0, y1, BYTES_LUMA, 1'b0, 1'b0);
            queue_write(area + area / 4 + chroma_idx_q, u_sum[8:1], 8'h00,
                        BYTES_CHROMA, 1'b0, 1'b0);
            queue_write(area + chroma_idx_q, v_sum[8:1], 8'h00,
                        BYTES_CHROMA, 1'b1, frame_end);
            chroma_idx_q = chroma_idx_q + 1'b1;
        end
        luma_q = luma_q + 2'd2;
        if (frame_end) begin
            restart_frame();
        end else if (row_end) begin
            col_q = '0;
            row_q = row_q + 1'b1;
        end else begin
            col_q = col_q + 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: write mismatch on %s: got 0x%0h, want 0x%0h",
                 $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_write();
        result_t      beat;
        frame_write_t want;
        beat = m_tdata[RESULT_W-1:0];
        if (expected_writes.size() == 0) begin
            report_mismatch("unexpected transaction", 32'(beat.write_address), 32'd0);
            return;
        end
        want = expected_writes.pop_front();
        if (beat.write_address !== want.beat.write_address)
            report_mismatch("write_address", 32'(beat.write_address),
                            32'(want.beat.write_address));
        if (beat.first_byte !== want.beat.first_byte)
            report_mismatch("first_byte", 32'(beat.first_byte), 32'(want.beat.first_byte));
        if (beat.second_byte !== want.beat.second_byte)
            report_mismatch("second_byte", 32'(beat.second_byte), 32'(want.beat.second_byte));
        if (beat.byte_count !== want.beat.byte_count)
            report_mismatch("byte_count", 32'(beat.byte_count), 32'(want.beat.byte_count));
        if (m_tdata[M_TDATA_W-1:RESULT_W] !== '0)
            report_mismatch("tdata padding", 32'(m_tdata[M_TDATA_W-1:RESULT_W]), 32'd0);
        if (m_tlast !== want.last)
            report_mismatch("last_of_run", 32'(m_tlast), 32'(want.last));
        if (m_tuser !== want.done)
            report_mismatch("frame_done", 32'(m_tuser), 32'(want.done));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            restart_frame();
            expected_writes.delete();
            mismatches = 0;
        end else begin
            if (m_tvalid && m_tready)
                check_write();
            if (cfg_we) begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg = cfg_wdata;
                else if (cfg_index == REG_FRAME_HEIGHT)
                    height_reg = cfg_wdata;
                restart_frame();
            end
            if (s_tvalid && s_tready)
                predict_writes(s_tdata);
        end
        outstanding = expected_writes.size();
    end

endmodule

>>> verif/tb_yuy2_to_yv12_converter.sv
`timescale 1ns / 100ps
// tb_yuy2_to_yv12_converter: drives macropixels and register writes into the
// converter and gives the verdict; checking lives in y2y_write_checker.
// Depends on y2y_pkg, yuy2_to_yv12_converter and y2y_write_checker.

module tb_yuy2_to_yv12_converter;

    import y2y_pkg::*;

    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE         = 4;
    localparam int RANDOM_ITEMS   = 135;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    int hold_requests = 0;
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;

    always #10 aclk = ~aclk;

    yuy2_to_yv12_converter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    y2y_write_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Write sink: random stalls, plus one long hold-off when requested
    initial begin : write_sink
        int stall;
        int holds_done;
        holds_done = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            stall = 0;
            if (holds_done != hold_requests) begin
                holds_done++;
                stall = LONG_HOLD;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 16);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("yuy2_to_yv12_converter regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] macropixel(input logic [7:0] y0, input logic [7:0] cb,
                                               input logic [7:0] y1, input logic [7:0] cr);
        return {cr, y1, cb, y0};
    endfunction

    function automatic logic [31:0] random_pixel();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Call at a falling edge; returns at the falling edge after the transaction
    task automatic send_macropixel(input logic [31:0] px);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_macropixel(random_pixel());
    endtask

    // Drop valid and hold until every predicted write has drained
    task automatic wait_for_writes();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int random_sent;
        int phase;
        int n;
        logic [CFG_DATA_W-1:0] width_val;
        logic [CFG_DATA_W-1:0] height_val;

        random_sent = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_FRAME_WIDTH;
        cfg_wdata   = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;

        // Reset geometry, even row only
        send_macropixel(32'h0000_0000);
        send_macropixel(32'hFFFF_FFFF);
        wait_for_writes();

        // 4x4 frame with chroma extremes and truncating averages
        write_register(REG_FRAME_WIDTH, 12'd4);
        write_register(REG_FRAME_HEIGHT, 12'd4);
        send_macropixel(macropixel(8'h00, 8'hFF, 8'hFF, 8'hFF));
        send_macropixel(macropixel(8'hFF, 8'h00, 8'h00, 8'h00));
        send_macropixel(macropixel(8'h80, 8'hFF, 8'h7F, 8'hFF));
        send_macropixel(macropixel(8'h01, 8'hFF, 8'hFE, 8'h01));
        send_macropixel(macropixel(8'h12, 8'h01, 8'h34, 8'h80));
        send_macropixel(macropixel(8'h56, 8'hFE, 8'h78, 8'h7F));
        send_macropixel(macropixel(8'h9A, 8'h00, 8'hBC, 8'h81));
        send_macropixel(macropixel(8'hDE, 8'hFF, 8'hF0, 8'h7F));
        wait_for_writes();

        // Sizes below two and odd round to 2x2; two back-to-back frames
        write_register(REG_FRAME_WIDTH, 12'd1);
        write_register(REG_FRAME_HEIGHT, 12'd3);
        send_random(4);
        wait_for_writes();

        // Zero width and oversize height: 2 x 2048
        write_register(REG_FRAME_WIDTH, 12'd0);
        write_register(REG_FRAME_HEIGHT, 12'hFFF);
        send_random(4);
        wait_for_writes();

        // Register write in the middle of a frame restarts it
        write_register(REG_FRAME_WIDTH, 12'd4);
        write_register(REG_FRAME_HEIGHT, 12'd4);
        send_random(3);
        wait_for_writes();
        write_register(REG_FRAME_WIDTH, 12'd4);
        send_random(4);
        wait_for_writes();

        // Largest frame, clamped to 2048 x 2048: first macropixels of the top row
        tx_idle_on = 1'b0;
        write_register(REG_FRAME_WIDTH, 12'hFFF);
        write_register(REG_FRAME_HEIGHT, 12'd2049);
        send_random(4);
        wait_for_writes();

        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) begin
                width_val  = CFG_DATA_W'($urandom_range(0, 4095));
                height_val = CFG_DATA_W'($urandom_range(0, 4095));
            end else begin
                width_val  = CFG_DATA_W'($urandom_range(0, 17));
                height_val = CFG_DATA_W'($urandom_range(0, 9));
            end
            case ($urandom_range(0, 2))
                0: write_register(REG_FRAME_WIDTH, width_val);
                1: write_register(REG_FRAME_HEIGHT, height_val);
                default: begin
                    write_register(REG_FRAME_WIDTH, width_val);
                    write_register(REG_FRAME_HEIGHT, height_val);
                end
            endcase
            n = (phase == 0) ? 40 : $urandom_range(4, 36);
            for (int i = 0; i < n; i++) begin
                // Long sink hold-off while the source keeps offering
                if (phase == 0 && i == 5)
                    hold_requests <= hold_requests + 1;
                // Source pauses until the converter has emptied
                if (phase == 1 && i == n / 2)
                    wait_for_writes();
                send_macropixel(random_pixel());
            end
            random_sent += n;
            wait_for_writes();
            phase++;
        end

        // Back-to-back traffic to the end: two full 8x4 frames
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        write_register(REG_FRAME_WIDTH, 12'd8);
        write_register(REG_FRAME_HEIGHT, 12'd4);
        send_random(32);
        wait_for_writes();
        repeat (8) @(negedge aclk);

        if (mismatches == 0 && outstanding == 0)
            $display("yuy2_to_yv12_converter regression: pass");
        else
            $display("yuy2_to_yv12_converter regression: fail");
        $finish;
    end

endmodule
